>>> rtl/core/ladrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ladrc_pkg: shared types and constants of the ADRC speed loop
// Number format, register indexes, the step program of the sequencer and the
// request and response records between the sequencer and its serial units.
// ----------------------------------------------------------------------------
`default_nettype none
package ladrc_pkg;

    localparam int STATE_WIDTH     = 48;
    localparam int FRAC_BITS       = 24;
    localparam int MAG_W           = 2 * STATE_WIDTH;
    localparam int BW_W            = 16;
    localparam int GAIN_W          = 24;
    localparam int COUNT_W         = 16;
    localparam int DUTY_W          = 10;
    localparam int FULL_DUTY_COUNT = 900;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 24;

    localparam int MUL_DIGIT  = 4;
    localparam int MUL_STEPS  = STATE_WIDTH / MUL_DIGIT;
    localparam int MUL_CNT_W  = $clog2(MUL_STEPS + 1);
    localparam int GAIN_SHIFT = 8;
    localparam int DIV_W      = STATE_WIDTH + GAIN_SHIFT;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int DIVISOR_W  = 24;

    localparam logic [STATE_WIDTH-1:0] SMAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
    localparam logic [STATE_WIDTH-1:0] SMIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};
    localparam logic [STATE_WIDTH-1:0] ONE_Q = STATE_WIDTH'(1) << FRAC_BITS;
    localparam logic [STATE_WIDTH-1:0] HIGH_CLAMP_Q = STATE_WIDTH'(16609444);
    localparam logic [STATE_WIDTH-1:0] LOW_CLAMP_Q  = STATE_WIDTH'(167773);

    localparam int SPEED_MUL = 200;
    localparam logic [DIVISOR_W-1:0] SPEED_DIVISOR = DIVISOR_W'(448 * 30);
    localparam logic [DIVISOR_W-1:0] STEP_DIVISOR  = DIVISOR_W'(100);

    localparam logic [BW_W-1:0]    WC_RESET     = BW_W'(1536);
    localparam logic [BW_W-1:0]    WO_RESET     = BW_W'(7680);
    localparam logic [BW_W-1:0]    V_RESET      = BW_W'(512);
    localparam logic [GAIN_W-1:0]  B0_RESET     = GAIN_W'(91469);
    localparam logic [COUNT_W-1:0] GLITCH_RESET = COUNT_W'(165);

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_WC     = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_WO     = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_V      = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_B0     = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_GLITCH = CFG_INDEX_W'(4);

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL_FRAC,
        OP_MUL_GAIN,
        OP_DIV_STEP,
        OP_DIV_GAIN,
        OP_SPEED,
        OP_CLAMP
    } op_t;

    typedef enum logic [4:0] {
        SEL_WO, SEL_WC, SEL_V, SEL_B0,
        SEL_Z1, SEL_Z2, SEL_Z3, SEL_LC, SEL_LS,
        SEL_G1, SEL_G2, SEL_G3, SEL_KP, SEL_KD,
        SEL_E, SEL_T0, SEL_T1
    } opnd_t;

    typedef struct packed {
        op_t   op;
        opnd_t a;
        opnd_t b;
        opnd_t dst;
    } step_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic [BW_W-1:0]   wc;
        logic [BW_W-1:0]   wo;
        logic [BW_W-1:0]   v;
        logic [GAIN_W-1:0] b0;
    } cfg_t;

    typedef struct packed {
        logic                   start;
        logic [STATE_WIDTH-1:0] a;
        logic [STATE_WIDTH-1:0] b;
        logic                   gain_shift;
    } mul_req_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     num;
        logic [DIVISOR_W-1:0] den;
        logic                 neg;
    } div_req_t;

    typedef struct packed {
        logic                   done;
        logic [STATE_WIDTH-1:0] y;
    } unit_rsp_t;

    typedef struct packed {
        logic              idle;
        logic              done;
        logic [DUTY_W-1:0] duty;
    } core_rsp_t;

    localparam int PROG_LEN = 29;
    localparam int PC_W     = $clog2(PROG_LEN);

    function automatic logic [STATE_WIDTH-1:0] mag_of(input logic [STATE_WIDTH-1:0] a);
        logic [STATE_WIDTH-1:0] m;
        m = a[STATE_WIDTH-1] ? (~a) + STATE_WIDTH'(1) : a;
        return m;
    endfunction

    function automatic logic [STATE_WIDTH-1:0] sat_from_mag(input logic [MAG_W-1:0] m,
                                                            input logic neg);
        logic                   over;
        logic [STATE_WIDTH-1:0] r;
        over = (|m[MAG_W-1:STATE_WIDTH])
             | (m[STATE_WIDTH-1] & (~neg | (|m[STATE_WIDTH-2:0])));
        if (over) begin
            r = neg ? SMIN : SMAX;
        end else if (neg) begin
            r = (~m[STATE_WIDTH-1:0]) + STATE_WIDTH'(1);
        end else begin
            r = m[STATE_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic step_t prog_step(input logic [PC_W-1:0] pc);
        step_t s;
        case (pc)
            PC_W'(0):  s = '{OP_SPEED,    SEL_LS, SEL_LS, SEL_LS};
            PC_W'(1):  s = '{OP_ADD,      SEL_WO, SEL_WO, SEL_G1};
            PC_W'(2):  s = '{OP_ADD,      SEL_G1, SEL_WO, SEL_G1};
            PC_W'(3):  s = '{OP_MUL_FRAC, SEL_G1, SEL_WO, SEL_G2};
            PC_W'(4):  s = '{OP_MUL_FRAC, SEL_WO, SEL_WO, SEL_G3};
            PC_W'(5):  s = '{OP_MUL_FRAC, SEL_G3, SEL_WO, SEL_G3};
            PC_W'(6):  s = '{OP_MUL_FRAC, SEL_WC, SEL_WC, SEL_KP};
            PC_W'(7):  s = '{OP_ADD,      SEL_WC, SEL_WC, SEL_KD};
            PC_W'(8):  s = '{OP_SUB,      SEL_Z1, SEL_LS, SEL_E};
            PC_W'(9):  s = '{OP_MUL_FRAC, SEL_G1, SEL_E,  SEL_T0};
            PC_W'(10): s = '{OP_SUB,      SEL_Z2, SEL_T0, SEL_T0};
            PC_W'(11): s = '{OP_DIV_STEP, SEL_T0, SEL_T0, SEL_T0};
            PC_W'(12): s = '{OP_ADD,      SEL_Z1, SEL_T0, SEL_Z1};
            PC_W'(13): s = '{OP_MUL_FRAC, SEL_G2, SEL_E,  SEL_T0};
            PC_W'(14): s = '{OP_SUB,      SEL_Z3, SEL_T0, SEL_T0};
            PC_W'(15): s = '{OP_MUL_GAIN, SEL_B0, SEL_LC, SEL_T1};
            PC_W'(16): s = '{OP_ADD,      SEL_T0, SEL_T1, SEL_T0};
            PC_W'(17): s = '{OP_DIV_STEP, SEL_T0, SEL_T0, SEL_T0};
            PC_W'(18): s = '{OP_MUL_FRAC, SEL_G3, SEL_E,  SEL_T1};
            PC_W'(19): s = '{OP_DIV_STEP, SEL_T1, SEL_T1, SEL_T1};
            PC_W'(20): s = '{OP_SUB,      SEL_Z3, SEL_T1, SEL_Z3};
            PC_W'(21): s = '{OP_ADD,      SEL_Z2, SEL_T0, SEL_Z2};
            PC_W'(22): s = '{OP_SUB,      SEL_V,  SEL_Z1, SEL_T0};
            PC_W'(23): s = '{OP_MUL_FRAC, SEL_KP, SEL_T0, SEL_T0};
            PC_W'(24): s = '{OP_MUL_FRAC, SEL_KD, SEL_Z2, SEL_T1};
            PC_W'(25): s = '{OP_SUB,      SEL_T0, SEL_T1, SEL_T0};
            PC_W'(26): s = '{OP_SUB,      SEL_T0, SEL_Z3, SEL_T0};
            PC_W'(27): s = '{OP_DIV_GAIN, SEL_T0, SEL_T0, SEL_T0};
            default:   s = '{OP_CLAMP,    SEL_T0, SEL_T0, SEL_LC};
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/ladrc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ladrc_mul: digit-serial signed fixed-point multiplier
// Shift-add over magnitudes, four multiplier bits per cycle, then a right
// shift by the fraction or gain width with saturation and sign restore.
// ----------------------------------------------------------------------------
`default_nettype none
module ladrc_mul import ladrc_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire mul_req_t  req,
    output unit_rsp_t      rsp
);

    localparam int SUM_W = STATE_WIDTH + MUL_DIGIT;

    logic [STATE_WIDTH-1:0] mcand_reg, mcand_next;
    logic [MAG_W-1:0]       prod_reg, prod_next;
    logic [MUL_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   neg_reg, neg_next;
    logic                   gain_reg, gain_next;
    logic [STATE_WIDTH-1:0] y_reg, y_next;
    logic [SUM_W-1:0]       part_sum;
    logic [MAG_W-1:0]       shifted;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        mcand_reg <= mcand_next;
        prod_reg  <= prod_next;
        cnt_reg   <= cnt_next;
        neg_reg   <= neg_next;
        gain_reg  <= gain_next;
        y_reg     <= y_next;
    end

    always_comb begin
        mcand_next = mcand_reg;
        prod_next  = prod_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        neg_next   = neg_reg;
        gain_next  = gain_reg;
        y_next     = y_reg;
        part_sum   = SUM_W'(prod_reg[MAG_W-1:STATE_WIDTH])
                   + SUM_W'(mcand_reg) * SUM_W'(prod_reg[MUL_DIGIT-1:0]);
        shifted    = gain_reg ? (prod_reg >> GAIN_SHIFT) : (prod_reg >> FRAC_BITS);
        if (req.start) begin
            mcand_next = mag_of(req.a);
            prod_next  = {{STATE_WIDTH{1'b0}}, mag_of(req.b)};
            cnt_next   = '0;
            busy_next  = 1'b1;
            neg_next   = req.a[STATE_WIDTH-1] ^ req.b[STATE_WIDTH-1];
            gain_next  = req.gain_shift;
        end else if (busy_reg) begin
            if (cnt_reg == MUL_CNT_W'(MUL_STEPS)) begin
                y_next    = sat_from_mag(shifted, neg_reg);
                done_next = 1'b1;
                busy_next = 1'b0;
            end else begin
                prod_next = {part_sum, prod_reg[STATE_WIDTH-1:MUL_DIGIT]};
                cnt_next  = cnt_reg + MUL_CNT_W'(1);
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.y    = y_reg;

endmodule
`default_nettype wire

>>> rtl/core/ladrc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ladrc_div: bit-serial restoring divider
// One quotient bit per cycle over the dividend magnitude, then saturation
// to the state width and sign restore.
// ----------------------------------------------------------------------------
`default_nettype none
module ladrc_div import ladrc_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire div_req_t  req,
    output unit_rsp_t      rsp
);

    logic [DIVISOR_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]       quo_reg, quo_next;
    logic [DIVISOR_W-1:0]   den_reg, den_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   neg_reg, neg_next;
    logic [STATE_WIDTH-1:0] y_reg, y_next;
    logic [DIVISOR_W:0]     trial;
    logic [DIVISOR_W:0]     diff;
    logic                   fits;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        y_reg   <= y_next;
    end

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        y_next    = y_reg;
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        fits      = trial >= {1'b0, den_reg};
        diff      = trial - {1'b0, den_reg};
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
            cnt_next  = '0;
            busy_next = 1'b1;
            neg_next  = req.neg;
        end else if (busy_reg) begin
            if (cnt_reg == DIV_CNT_W'(DIV_W)) begin
                y_next    = sat_from_mag(MAG_W'(quo_reg), neg_reg);
                done_next = 1'b1;
                busy_next = 1'b0;
            end else begin
                rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], fits};
                cnt_next = cnt_reg + DIV_CNT_W'(1);
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.y    = y_reg;

endmodule
`default_nettype wire

>>> rtl/core/ladrc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ladrc_core: step sequencer and value registers of the ADRC loop
// Walks the step program, drives the serial multiplier and divider, does the
// saturating add/subtract and the final clamp and duty conversion.
// ----------------------------------------------------------------------------
`default_nettype none
module ladrc_core import ladrc_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cfg_t               cfg,
    input  wire logic               start,
    input  wire logic [COUNT_W-1:0] count,
    input  wire logic               rejected,
    input  wire logic               ack,
    output core_rsp_t               rsp
);

    localparam int SPD_W     = COUNT_W + 8;
    localparam int DUTY_PR_W = FRAC_BITS + 1 + DUTY_W;

    seq_state_t             state_reg, state_next;
    logic [PC_W-1:0]        pc_reg, pc_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic                   rej_reg, rej_next;
    logic [DUTY_W-1:0]      duty_reg, duty_next;

    logic [STATE_WIDTH-1:0] z1_reg, z1_next, z2_reg, z2_next, z3_reg, z3_next;
    logic [STATE_WIDTH-1:0] lc_reg, lc_next, ls_reg, ls_next;
    logic [STATE_WIDTH-1:0] g1_reg, g1_next, g2_reg, g2_next, g3_reg, g3_next;
    logic [STATE_WIDTH-1:0] kp_reg, kp_next, kd_reg, kd_next, e_reg, e_next;
    logic [STATE_WIDTH-1:0] t0_reg, t0_next, t1_reg, t1_next;

    step_t                  step;
    logic [STATE_WIDTH-1:0] opa, opb, addend, clamped, wr_data;
    logic [STATE_WIDTH:0]   sum;
    logic [STATE_WIDTH-1:0] alu_sum;
    logic                   wr_en;
    logic [GAIN_W-1:0]      b0_eff;
    logic [SPD_W-1:0]       spd_prod;
    logic [DUTY_PR_W-1:0]   duty_prod;
    mul_req_t               mul_req;
    div_req_t               div_req;
    unit_rsp_t              mul_rsp, div_rsp;

    ladrc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    ladrc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            z1_reg    <= '0;
            z2_reg    <= '0;
            z3_reg    <= '0;
            lc_reg    <= '0;
            ls_reg    <= '0;
        end else begin
            state_reg <= state_next;
            z1_reg    <= z1_next;
            z2_reg    <= z2_next;
            z3_reg    <= z3_next;
            lc_reg    <= lc_next;
            ls_reg    <= ls_next;
        end
        pc_reg    <= pc_next;
        count_reg <= count_next;
        rej_reg   <= rej_next;
        duty_reg  <= duty_next;
        g1_reg    <= g1_next;
        g2_reg    <= g2_next;
        g3_reg    <= g3_next;
        kp_reg    <= kp_next;
        kd_reg    <= kd_next;
        e_reg     <= e_next;
        t0_reg    <= t0_next;
        t1_reg    <= t1_next;
    end

    assign step   = prog_step(pc_reg);
    assign b0_eff = (cfg.b0 == '0) ? GAIN_W'(1) : cfg.b0;

    always_comb begin
        case (step.a)
            SEL_WO:  opa = STATE_WIDTH'({cfg.wo, 16'h0000});
            SEL_WC:  opa = STATE_WIDTH'({cfg.wc, 16'h0000});
            SEL_V:   opa = STATE_WIDTH'({cfg.v, 16'h0000});
            SEL_B0:  opa = STATE_WIDTH'(b0_eff);
            SEL_Z1:  opa = z1_reg;
            SEL_Z2:  opa = z2_reg;
            SEL_Z3:  opa = z3_reg;
            SEL_LC:  opa = lc_reg;
            SEL_LS:  opa = ls_reg;
            SEL_G1:  opa = g1_reg;
            SEL_G2:  opa = g2_reg;
            SEL_G3:  opa = g3_reg;
            SEL_KP:  opa = kp_reg;
            SEL_KD:  opa = kd_reg;
            SEL_E:   opa = e_reg;
            SEL_T0:  opa = t0_reg;
            SEL_T1:  opa = t1_reg;
            default: opa = '0;
        endcase
    end

    always_comb begin
        case (step.b)
            SEL_WO:  opb = STATE_WIDTH'({cfg.wo, 16'h0000});
            SEL_WC:  opb = STATE_WIDTH'({cfg.wc, 16'h0000});
            SEL_V:   opb = STATE_WIDTH'({cfg.v, 16'h0000});
            SEL_B0:  opb = STATE_WIDTH'(b0_eff);
            SEL_Z1:  opb = z1_reg;
            SEL_Z2:  opb = z2_reg;
            SEL_Z3:  opb = z3_reg;
            SEL_LC:  opb = lc_reg;
            SEL_LS:  opb = ls_reg;
            SEL_G1:  opb = g1_reg;
            SEL_G2:  opb = g2_reg;
            SEL_G3:  opb = g3_reg;
            SEL_KP:  opb = kp_reg;
            SEL_KD:  opb = kd_reg;
            SEL_E:   opb = e_reg;
            SEL_T0:  opb = t0_reg;
            SEL_T1:  opb = t1_reg;
            default: opb = '0;
        endcase
    end

    // saturating add and subtract; negating the most negative value gives the most positive
    always_comb begin
        if (step.op == OP_SUB) begin
            addend = (opb == SMIN) ? SMAX : (~opb) + STATE_WIDTH'(1);
        end else begin
            addend = opb;
        end
        sum = {opa[STATE_WIDTH-1], opa} + {addend[STATE_WIDTH-1], addend};
        if (sum[STATE_WIDTH] != sum[STATE_WIDTH-1]) begin
            alu_sum = sum[STATE_WIDTH] ? SMIN : SMAX;
        end else begin
            alu_sum = sum[STATE_WIDTH-1:0];
        end
    end

    always_comb begin
        if ($signed(opa) > $signed(ONE_Q)) begin
            clamped = HIGH_CLAMP_Q;
        end else if (opa[STATE_WIDTH-1]) begin
            clamped = LOW_CLAMP_Q;
        end else begin
            clamped = opa;
        end
        duty_prod = DUTY_PR_W'(clamped[FRAC_BITS:0]) * DUTY_PR_W'(FULL_DUTY_COUNT);
        spd_prod  = SPD_W'(count_reg) * SPD_W'(SPEED_MUL);
    end

    always_comb begin
        mul_req.start      = 1'b0;
        mul_req.a          = opa;
        mul_req.b          = opb;
        mul_req.gain_shift = (step.op == OP_MUL_GAIN);
        div_req.start      = 1'b0;
        case (step.op)
            OP_SPEED: begin
                div_req.num = {{GAIN_SHIFT{1'b0}}, STATE_WIDTH'(spd_prod) << FRAC_BITS};
                div_req.den = SPEED_DIVISOR;
                div_req.neg = 1'b0;
            end
            OP_DIV_GAIN: begin
                div_req.num = {mag_of(opa), {GAIN_SHIFT{1'b0}}};
                div_req.den = DIVISOR_W'(b0_eff);
                div_req.neg = opa[STATE_WIDTH-1];
            end
            default: begin
                div_req.num = {{GAIN_SHIFT{1'b0}}, mag_of(opa)};
                div_req.den = STEP_DIVISOR;
                div_req.neg = opa[STATE_WIDTH-1];
            end
        endcase

        state_next = state_reg;
        pc_next    = pc_reg;
        count_next = count_reg;
        rej_next   = rej_reg;
        duty_next  = duty_reg;
        wr_en      = 1'b0;
        wr_data    = alu_sum;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    count_next = count;
                    rej_next   = rejected;
                    pc_next    = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN: begin
                case (step.op)
                    OP_ADD, OP_SUB: begin
                        wr_en   = 1'b1;
                        pc_next = pc_reg + PC_W'(1);
                    end
                    OP_MUL_FRAC, OP_MUL_GAIN: begin
                        mul_req.start = 1'b1;
                        state_next    = S_WAIT;
                    end
                    OP_SPEED: begin
                        if (rej_reg) begin
                            pc_next = pc_reg + PC_W'(1);
                        end else begin
                            div_req.start = 1'b1;
                            state_next    = S_WAIT;
                        end
                    end
                    OP_DIV_STEP, OP_DIV_GAIN: begin
                        div_req.start = 1'b1;
                        state_next    = S_WAIT;
                    end
                    OP_CLAMP: begin
                        wr_en      = 1'b1;
                        wr_data    = clamped;
                        duty_next  = duty_prod[FRAC_BITS+DUTY_W-1:FRAC_BITS];
                        state_next = S_DONE;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_WAIT: begin
                if (mul_rsp.done || div_rsp.done) begin
                    wr_en      = 1'b1;
                    wr_data    = mul_rsp.done ? mul_rsp.y : div_rsp.y;
                    pc_next    = pc_reg + PC_W'(1);
                    state_next = S_RUN;
                end
            end
            S_DONE: begin
                if (ack) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        z1_next = z1_reg;
        z2_next = z2_reg;
        z3_next = z3_reg;
        lc_next = lc_reg;
        ls_next = ls_reg;
        g1_next = g1_reg;
        g2_next = g2_reg;
        g3_next = g3_reg;
        kp_next = kp_reg;
        kd_next = kd_reg;
        e_next  = e_reg;
        t0_next = t0_reg;
        t1_next = t1_reg;
        if (wr_en) begin
            case (step.dst)
                SEL_Z1:  z1_next = wr_data;
                SEL_Z2:  z2_next = wr_data;
                SEL_Z3:  z3_next = wr_data;
                SEL_LC:  lc_next = wr_data;
                SEL_LS:  ls_next = wr_data;
                SEL_G1:  g1_next = wr_data;
                SEL_G2:  g2_next = wr_data;
                SEL_G3:  g3_next = wr_data;
                SEL_KP:  kp_next = wr_data;
                SEL_KD:  kd_next = wr_data;
                SEL_E:   e_next  = wr_data;
                SEL_T0:  t0_next = wr_data;
                SEL_T1:  t1_next = wr_data;
                default: ;
            endcase
        end
    end

    assign rsp.idle = (state_reg == S_IDLE);
    assign rsp.done = (state_reg == S_DONE);
    assign rsp.duty = duty_reg;

endmodule
`default_nettype wire

>>> rtl/core/linear_adrc_speed_loop.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_adrc_speed_loop: ADRC speed loop with third-order observer
// Each input item runs the step program: five divides on the bit-serial divider
//   (four when the count is rejected) and ten multiplies on the 4-bit digit
//   multiplier. Items are taken one at a time, only while the core is idle; the
//   next item is taken while a result still waits on the output. Reset:
//   synchronous, active low; observer state, last control and last speed clear
//   to zero, registers take their defaults.
// ----------------------------------------------------------------------------
`default_nettype none
module linear_adrc_speed_loop import ladrc_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [COUNT_W-1:0]     s_pulse_count,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [DUTY_W-1:0]           m_duty_cmp,
    output logic                        m_sample_rejected,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [BW_W-1:0]    wc_reg, wo_reg, v_reg;
    logic [GAIN_W-1:0]  b0_reg;
    logic [COUNT_W-1:0] glitch_reg;
    logic               rej_reg, rej_next;
    logic               m_valid_reg, m_valid_next;
    logic [DUTY_W-1:0]  duty_reg, duty_next;
    logic               m_rej_reg, m_rej_next;
    logic               start;
    logic               ack;
    logic               rejected;
    cfg_t               cfg;
    core_rsp_t          core_rsp;

    assign cfg.wc = wc_reg;
    assign cfg.wo = wo_reg;
    assign cfg.v  = v_reg;
    assign cfg.b0 = b0_reg;

    ladrc_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .start    (start),
        .count    (s_pulse_count),
        .rejected (rejected),
        .ack      (ack),
        .rsp      (core_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wc_reg     <= WC_RESET;
            wo_reg     <= WO_RESET;
            v_reg      <= V_RESET;
            b0_reg     <= B0_RESET;
            glitch_reg <= GLITCH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_IDX_WC) begin
                wc_reg <= cfg_data[BW_W-1:0];
            end
            if (cfg_index == CFG_IDX_WO) begin
                wo_reg <= cfg_data[BW_W-1:0];
            end
            if (cfg_index == CFG_IDX_V) begin
                v_reg <= cfg_data[BW_W-1:0];
            end
            if (cfg_index == CFG_IDX_B0) begin
                b0_reg <= cfg_data[GAIN_W-1:0];
            end
            if (cfg_index == CFG_IDX_GLITCH) begin
                glitch_reg <= cfg_data[COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        rej_reg   <= rej_next;
        duty_reg  <= duty_next;
        m_rej_reg <= m_rej_next;
    end

    always_comb begin
        rejected     = s_pulse_count >= glitch_reg;
        start        = s_valid && core_rsp.idle;
        ack          = core_rsp.done && (!m_valid_reg || m_ready);
        rej_next     = start ? rejected : rej_reg;
        m_valid_next = m_valid_reg;
        duty_next    = duty_reg;
        m_rej_next   = m_rej_reg;
        if (ack) begin
            m_valid_next = 1'b1;
            duty_next    = core_rsp.duty;
            m_rej_next   = rej_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign s_ready           = core_rsp.idle;
    assign cfg_ready         = 1'b1;
    assign m_valid           = m_valid_reg;
    assign m_duty_cmp        = duty_reg;
    assign m_sample_rejected = m_rej_reg;

endmodule
`default_nettype wire

>>> rtl/core/ladrc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ladrc_checker: port-level checks of the ADRC speed loop
// Output handshake rules, duty range and one item in flight at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module ladrc_checker import ladrc_pkg::*; (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [DUTY_W-1:0] m_duty_cmp,
    input wire logic              m_sample_rejected
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_duty_cmp) && $stable(m_sample_rejected))
        else $error("result item changed while stalled");

    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_duty_cmp <= DUTY_W'(FULL_DUTY_COUNT))
        else $error("duty above full scale");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in work");

endmodule

bind linear_adrc_speed_loop ladrc_checker u_ladrc_checker (.*);
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the ADRC speed loop
// Drives encoder counts and register writes through valid/ready channels,
// predicts each PWM duty with a fixed-point model of the observer and PD law,
// and compares every result item in order, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb import ladrc_pkg::*;;

    typedef logic signed [127:0] wide_t;
    typedef struct {
        logic [DUTY_W-1:0] duty;
        logic              rejected;
    } duty_item_t;

    localparam longint QMAX = (longint'(1) <<< (STATE_WIDTH - 1)) - 1;
    localparam longint QMIN = -QMAX - 1;
    localparam longint QONE = longint'(1) <<< FRAC_BITS;
    localparam longint QHIGH = 16609444;
    localparam longint QLOW = 167773;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPARE = CFG_INDEX_W'(6);
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_LAST  = CFG_INDEX_W'(7);

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [COUNT_W-1:0] s_pulse_count = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [DUTY_W-1:0] m_duty_cmp;
    logic m_sample_rejected;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    linear_adrc_speed_loop u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_pulse_count(s_pulse_count),
        .m_valid(m_valid), .m_ready(m_ready), .m_duty_cmp(m_duty_cmp),
        .m_sample_rejected(m_sample_rejected),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // model state and registers
    longint wc_reg, wo_reg, v_reg, b0_reg, glitch_reg;
    longint z1, z2, z3, ctrl_prev, speed_prev;

    duty_item_t duty_q[$];
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int rejects_seen = 0;
    int cfg_writes = 0;
    bit idle_enable = 1'b1;

    function automatic longint sat_w(wide_t x);
        if (x > wide_t'(QMAX)) return QMAX;
        if (x < wide_t'(QMIN)) return QMIN;
        return longint'(x);
    endfunction

    function automatic longint q_add(longint a, longint b);
        return sat_w(wide_t'(a) + wide_t'(b));
    endfunction

    function automatic longint q_sub(longint a, longint b);
        return q_add(a, sat_w(-wide_t'(b)));
    endfunction

    function automatic longint from_mag(wide_t m, bit neg);
        if (neg) return (m > wide_t'(QMAX) + 1) ? QMIN : longint'(-m);
        return (m > wide_t'(QMAX)) ? QMAX : longint'(m);
    endfunction

    function automatic longint q_mul(longint a, longint b, int sh);
        wide_t ma, mb;
        ma = (a < 0) ? -wide_t'(a) : wide_t'(a);
        mb = (b < 0) ? -wide_t'(b) : wide_t'(b);
        return from_mag((ma * mb) >> sh, (a < 0) != (b < 0));
    endfunction

    function automatic longint q_gain_div(longint num, longint d);
        wide_t m;
        m = (num < 0) ? -wide_t'(num) : wide_t'(num);
        return from_mag((m << GAIN_SHIFT) / wide_t'(d), num < 0);
    endfunction

    task automatic predict_duty(input logic [COUNT_W-1:0] count, output duty_item_t r);
        longint b0, wo, wc, v, g1, g2, g3, kp, kd, e, n1, n2, n3, t, u0, u;
        b0 = (b0_reg == 0) ? 1 : b0_reg;
        wo = wo_reg <<< 16;
        wc = wc_reg <<< 16;
        v = v_reg <<< 16;
        r.rejected = (longint'(count) >= glitch_reg);
        if (!r.rejected)
            speed_prev = ((longint'(count) * SPEED_MUL) <<< FRAC_BITS) / (448 * 30);
        g1 = q_add(q_add(wo, wo), wo);
        g2 = q_mul(g1, wo, FRAC_BITS);
        g3 = q_mul(q_mul(wo, wo, FRAC_BITS), wo, FRAC_BITS);
        kp = q_mul(wc, wc, FRAC_BITS);
        kd = q_add(wc, wc);
        e = q_sub(z1, speed_prev);
        n1 = q_add(z1, q_sub(z2, q_mul(g1, e, FRAC_BITS)) / 100);
        t = q_sub(z3, q_mul(g2, e, FRAC_BITS));
        t = q_add(t, q_mul(b0, ctrl_prev, GAIN_SHIFT));
        n2 = q_add(z2, t / 100);
        n3 = q_sub(z3, q_mul(g3, e, FRAC_BITS) / 100);
        z1 = n1;
        z2 = n2;
        z3 = n3;
        u0 = q_sub(q_mul(kp, q_sub(v, z1), FRAC_BITS), q_mul(kd, z2, FRAC_BITS));
        u = q_gain_div(q_sub(u0, z3), b0);
        if (u > QONE) u = QHIGH;
        if (u < 0) u = QLOW;
        ctrl_prev = u;
        r.duty = DUTY_W'((u * FULL_DUTY_COUNT) >>> FRAC_BITS);
    endtask

    function automatic bit idle_now();
        return idle_enable && ($urandom_range(99) < 30);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
    endtask

    task automatic send_count(input logic [COUNT_W-1:0] count);
        duty_item_t r;
        @(negedge aclk);
        while (idle_now()) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_pulse_count = count;
        do @(posedge aclk); while (!s_ready);
        predict_duty(count, r);
        duty_q.push_back(r);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (duty_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = d;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_IDX_WC:     wc_reg = d[15:0];
            CFG_IDX_WO:     wo_reg = d[15:0];
            CFG_IDX_V:      v_reg = d[15:0];
            CFG_IDX_B0:     b0_reg = d;
            CFG_IDX_GLITCH: glitch_reg = d[15:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_all(input logic [15:0] wc, input logic [15:0] wo, input logic [15:0] v,
                           input logic [23:0] b0, input logic [15:0] gl);
        write_reg(CFG_IDX_WC, {8'h00, wc});
        write_reg(CFG_IDX_WO, {8'h00, wo});
        write_reg(CFG_IDX_V, {8'h00, v});
        write_reg(CFG_IDX_B0, b0);
        write_reg(CFG_IDX_GLITCH, {8'h00, gl});
    endtask

    always @(negedge aclk) m_ready <= !idle_now();

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (duty_q.size() == 0) begin
                report_mismatch("unexpected item", 0, 0);
            end else begin
                if (m_duty_cmp !== duty_q[0].duty)
                    report_mismatch("duty_cmp", m_duty_cmp, duty_q[0].duty);
                if (m_sample_rejected !== duty_q[0].rejected)
                    report_mismatch("sample_rejected", m_sample_rejected, duty_q[0].rejected);
                if (duty_q[0].rejected) rejects_seen++;
                void'(duty_q.pop_front());
            end
            results_seen++;
        end
    end

    task automatic test_reset_defaults();
        send_count(16'd0);
        send_count(16'd1);
        send_count(16'd100);
        send_count(16'd164);
        send_count(16'd165);
        send_count(16'hFFFF);
        send_count(16'd80);
        send_count(16'd150);
        drain();
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_IDX_SPARE, 24'hFFFFFF);
        write_reg(CFG_IDX_LAST, 24'h5A5A5A);
        set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 16'hFFFF);
        send_count(16'hFFFE);
        send_count(16'hFFFF);
        send_count(16'h0000);
        drain();
        set_all(16'h0000, 16'h0000, 16'h0000, 24'h000000, 16'h0000);
        send_count(16'd10);
        send_count(16'hFFFF);
        drain();
        set_all(16'd1536, 16'hFFFF, 16'd512, 24'd1, 16'd165);
        repeat (4) send_count(16'(($urandom_range(164))));
        drain();
        set_all(16'hFFFF, 16'd7680, 16'hFFFF, 24'd91469, 16'd165);
        repeat (4) send_count(16'(($urandom_range(164))));
        drain();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 6; ph++) begin
            logic [15:0] gl;
            idle_enable = (ph != 2);
            if (ph == 0) begin
                set_all(16'd1536, 16'd7680, 16'd512, 24'd91469, 16'd165);
            end else begin
                gl = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2000));
                set_all(($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3000)),
                        ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(12000)),
                        ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4000)),
                        ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(1, 200000)),
                        gl);
            end
            for (int i = 0; i < 240; i++) begin
                if ($urandom_range(99) < 70 && glitch_reg > 0)
                    send_count(16'($urandom_range(int'(glitch_reg) - 1)));
                else
                    send_count(16'($urandom));
            end
            drain();
        end
    endtask

    initial begin
        wc_reg = 1536; wo_reg = 7680; v_reg = 512; b0_reg = 91469; glitch_reg = 165;
        z1 = 0; z2 = 0; z3 = 0; ctrl_prev = 0; speed_prev = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_reset_defaults();
        test_register_extremes();
        test_random_phases();
        repeat (600) @(posedge aclk);
        $display("sent %0d counts, checked %0d results (%0d rejected), %0d register writes",
                 items_sent, results_seen, rejects_seen, cfg_writes);
        if (errors == 0 && duty_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #60ms;
        $display("timeout with %0d results outstanding", duty_q.size());
        $display("TB_ERROR");
        $finish;
    end
endmodule

>>> linear_adrc_speed_loop.f
rtl/core/ladrc_pkg.sv
rtl/core/ladrc_mul.sv
rtl/core/ladrc_div.sv
rtl/core/ladrc_core.sv
rtl/core/linear_adrc_speed_loop.sv
rtl/core/ladrc_checker.sv
verif/tb.sv
